// ----- src/dmwtc_pkg.sv -----
// ============================================================================
// dmwtc_pkg
// Shared sizes, types and helpers for the direct-mapped write-through cache.
// ============================================================================
`default_nettype none

package dmwtc_pkg;

    localparam int LINE_COUNT   = 8;
    localparam int ADDRESS_BITS = 7;
    localparam int WORD_BITS    = 16;
    localparam int INDEX_SHIFT  = 4;
    localparam int COUNT_BITS   = 32;

    localparam int INDEX_BITS = $clog2(LINE_COUNT);
    localparam int TAG_BITS   = ADDRESS_BITS - INDEX_BITS;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // register the incoming access
        logic execute;   // look up, update the line and the counters
    } cmd_t;

    function automatic logic [INDEX_BITS-1:0] index_of(input logic [ADDRESS_BITS-1:0] a);
        return a[INDEX_SHIFT +: INDEX_BITS];
    endfunction

    // The tag keeps every address bit outside the index field, in order.
    function automatic logic [TAG_BITS-1:0] tag_of(input logic [ADDRESS_BITS-1:0] a);
        logic [TAG_BITS-1:0] t;
        int j;
        t = '0;
        j = 0;
        for (int i = 0; i < ADDRESS_BITS; i++) begin
            if (i < INDEX_SHIFT || i >= INDEX_SHIFT + INDEX_BITS) begin
                t[j] = a[i];
                j++;
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- src/dmwtc_if.sv -----
// ============================================================================
// dmwtc_req_if / dmwtc_rsp_if
// Valid/ready channels for cache accesses and their results.
// ============================================================================
`default_nettype none

interface dmwtc_req_if;
    import dmwtc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [ADDRESS_BITS-1:0] address;
    logic [WORD_BITS-1:0]    write_value;
    logic [WORD_BITS-1:0]    mem_data;
    logic                    mem_fault;

    modport source (output valid, op, address, write_value, mem_data, mem_fault,
                    input ready);
    modport sink   (input valid, op, address, write_value, mem_data, mem_fault,
                    output ready);
endinterface

interface dmwtc_rsp_if;
    import dmwtc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  status;
    logic                  hit;
    logic [WORD_BITS-1:0]  read_data;
    logic [COUNT_BITS-1:0] access_total;
    logic [COUNT_BITS-1:0] hit_total;
    logic [COUNT_BITS-1:0] miss_total;

    modport source (output valid, status, hit, read_data, access_total, hit_total,
                    miss_total, input ready);
    modport sink   (input valid, status, hit, read_data, access_total, hit_total,
                    miss_total, output ready);
endinterface

`default_nettype wire

// ----- src/dmwtc_ctrl.sv -----
// ============================================================================
// dmwtc_ctrl
// Sequencer: takes one access beat, runs it once the result slot is free.
// ============================================================================
`default_nettype none

module dmwtc_ctrl
    import dmwtc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   slot_free;

    // The result register can take a new result when empty or being drained.
    assign slot_free   = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.capture = in_valid && in_ready;
    assign cmd.execute = (state_reg == S_EXEC) && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (in_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/dmwtc_datapath.sv -----
// ============================================================================
// dmwtc_datapath
// Access register, line store, hit/miss counters and result register.
// ============================================================================
`default_nettype none

module dmwtc_datapath
    import dmwtc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmd_t                    cmd,
    input  wire logic                    op,
    input  wire logic [ADDRESS_BITS-1:0] address,
    input  wire logic [WORD_BITS-1:0]    write_value,
    input  wire logic [WORD_BITS-1:0]    mem_data,
    input  wire logic                    mem_fault,
    output logic                         status,
    output logic                         hit,
    output logic [WORD_BITS-1:0]         read_data,
    output logic [COUNT_BITS-1:0]        access_total,
    output logic [COUNT_BITS-1:0]        hit_total,
    output logic [COUNT_BITS-1:0]        miss_total
);

    op_t                     op_reg;
    logic [ADDRESS_BITS-1:0] address_reg;
    logic [WORD_BITS-1:0]    write_value_reg;
    logic [WORD_BITS-1:0]    mem_data_reg;
    logic                    fault_reg;

    logic [LINE_COUNT-1:0]   line_valid_reg;
    logic [TAG_BITS-1:0]     line_tag_reg  [LINE_COUNT];
    logic [WORD_BITS-1:0]    line_word_reg [LINE_COUNT];

    logic [COUNT_BITS-1:0]   access_count_reg;
    logic [COUNT_BITS-1:0]   hit_count_reg;
    logic [COUNT_BITS-1:0]   miss_count_reg;

    logic                    status_reg;
    logic                    hit_reg;
    logic [WORD_BITS-1:0]    read_data_reg;

    logic [INDEX_BITS-1:0]   idx;
    logic [TAG_BITS-1:0]     tag;
    logic                    match;

    assign idx   = index_of(address_reg);
    assign tag   = tag_of(address_reg);
    assign match = line_valid_reg[idx] && (line_tag_reg[idx] == tag);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg          <= op_t'(op);
            address_reg     <= address;
            write_value_reg <= write_value;
            mem_data_reg    <= mem_data;
            fault_reg       <= mem_fault;
        end
    end

    // Line tags and words are only read behind a set valid bit.
    always_ff @(posedge clk)
    begin
        if (cmd.execute && !fault_reg)
        begin
            if (op_reg == OP_WRITE)
            begin
                line_tag_reg[idx]  <= tag;
                line_word_reg[idx] <= write_value_reg;
            end
            else if (!match)
            begin
                line_tag_reg[idx]  <= tag;
                line_word_reg[idx] <= mem_data_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            read_data_reg <= '0;
            unique case (op_reg)
                OP_WRITE:
                begin
                    if (fault_reg)
                    begin
                        status_reg <= 1'b1;
                    end
                    else
                    begin
                        hit_reg <= match;
                    end
                end
                OP_READ:
                begin
                    if (match)
                    begin
                        hit_reg       <= 1'b1;
                        read_data_reg <= line_word_reg[idx];
                    end
                    else if (fault_reg)
                    begin
                        status_reg <= 1'b1;
                    end
                    else
                    begin
                        read_data_reg <= mem_data_reg;
                    end
                end
                default:
                begin
                    status_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg   <= '0;
            access_count_reg <= '0;
            hit_count_reg    <= '0;
            miss_count_reg   <= '0;
        end
        else if (cmd.execute)
        begin
            access_count_reg <= access_count_reg + 1'b1;
            // A faulted write counts neither a hit nor a miss.
            if (!(op_reg == OP_WRITE && fault_reg))
            begin
                if (match)
                begin
                    hit_count_reg <= hit_count_reg + 1'b1;
                end
                else
                begin
                    miss_count_reg <= miss_count_reg + 1'b1;
                end
            end
            if (!fault_reg && !match)
            begin
                line_valid_reg[idx] <= 1'b1;
            end
        end
    end

    assign status       = status_reg;
    assign hit          = hit_reg;
    assign read_data    = read_data_reg;
    assign access_total = access_count_reg;
    assign hit_total    = hit_count_reg;
    assign miss_total   = miss_count_reg;

endmodule

`default_nettype wire

// ----- src/direct_mapped_write_through_cache.sv -----
// ============================================================================
// direct_mapped_write_through_cache
// Eight-line, one-word-per-line, write-through, write-allocate cache.
// ============================================================================
// Each access beat on req carries the backing memory's word and fault flag,
// and yields one result beat on rsp with status, hit, read data and the
// running access, hit and miss totals (wrapping at 32 bits). An access is
// first registered from the beat, then looked up in the line registers while
// lines and counters are updated; no new beat is taken until it has executed.
// A finished result waits in its own register while the next access
// is taken in; execution stalls only if that result is still untaken.
`default_nettype none

module direct_mapped_write_through_cache
    import dmwtc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    dmwtc_req_if.sink req,
    dmwtc_rsp_if.source rsp
);

    cmd_t cmd;

    dmwtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    dmwtc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (req.op),
        .address      (req.address),
        .write_value  (req.write_value),
        .mem_data     (req.mem_data),
        .mem_fault    (req.mem_fault),
        .status       (rsp.status),
        .hit          (rsp.hit),
        .read_data    (rsp.read_data),
        .access_total (rsp.access_total),
        .hit_total    (rsp.hit_total),
        .miss_total   (rsp.miss_total)
    );

endmodule

`default_nettype wire

// ----- verif/dmwtc_access_checker.sv -----
// ============================================================================
// dmwtc_access_checker
// Watches the access and result channels of the write-through cache, keeps
// its own copy of the lines and totals, and checks every result beat.
// ============================================================================

module dmwtc_access_checker
    import dmwtc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    dmwtc_req_if  req,
    dmwtc_rsp_if  rsp,
    output int    fail_count,
    output int    pending,
    output int    checked,
    output int    hits_seen,
    output int    faults_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                  status;
        logic                  hit;
        logic [WORD_BITS-1:0]  read_data;
        logic [COUNT_BITS-1:0] access_total;
        logic [COUNT_BITS-1:0] hit_total;
        logic [COUNT_BITS-1:0] miss_total;
    } outcome_t;

    logic                  line_present [LINE_COUNT];
    logic [TAG_BITS-1:0]   line_key     [LINE_COUNT];
    logic [WORD_BITS-1:0]  line_data    [LINE_COUNT];
    logic [COUNT_BITS-1:0] n_access;
    logic [COUNT_BITS-1:0] n_hit;
    logic [COUNT_BITS-1:0] n_miss;

    outcome_t awaited_outcomes [$];

    // Applies one access to the shadow cache and returns the result it must produce.
    function automatic outcome_t predict_access(input op_t kind,
                                                input logic [ADDRESS_BITS-1:0] addr,
                                                input logic [WORD_BITS-1:0] wval,
                                                input logic [WORD_BITS-1:0] mval,
                                                input logic fault);
        int                  slot;
        int                  upper;
        logic [TAG_BITS-1:0] key;
        logic                match;
        outcome_t            o;
        slot  = (int'(addr) >> INDEX_SHIFT) % LINE_COUNT;
        upper = (int'(addr) >> INDEX_SHIFT) / LINE_COUNT;
        // Every bit outside the index field belongs to the tag.
        key   = TAG_BITS'((upper << INDEX_SHIFT) | (int'(addr) & ((1 << INDEX_SHIFT) - 1)));
        match = line_present[slot] && (line_key[slot] == key);
        o     = '0;
        n_access++;
        if (kind == OP_WRITE) begin
            // A faulting write leaves the lines and the hit and miss totals alone.
            if (fault) begin
                o.status = 1'b1;
            end
            else begin
                if (match) begin
                    n_hit++;
                    o.hit = 1'b1;
                end
                else begin
                    n_miss++;
                    line_present[slot] = 1'b1;
                    line_key[slot]     = key;
                end
                line_data[slot] = wval;
            end
        end
        else if (match) begin
            n_hit++;
            o.hit       = 1'b1;
            o.read_data = line_data[slot];
        end
        else begin
            n_miss++;
            if (fault) begin
                o.status = 1'b1;
            end
            else begin
                line_present[slot] = 1'b1;
                line_key[slot]     = key;
                line_data[slot]    = mval;
                o.read_data        = mval;
            end
        end
        o.access_total = n_access;
        o.hit_total    = n_hit;
        o.miss_total   = n_miss;
        return o;
    endfunction

    function automatic void compare_field(input string name,
                                          input logic [COUNT_BITS-1:0] want,
                                          input logic [COUNT_BITS-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        outcome_t want;
        if (!rst_n) begin
            for (int i = 0; i < LINE_COUNT; i++) begin
                line_present[i] = 1'b0;
                line_key[i]     = '0;
                line_data[i]    = '0;
            end
            n_access = '0;
            n_hit    = '0;
            n_miss   = '0;
            awaited_outcomes.delete();
            fail_count  = 0;
            pending     = 0;
            checked     = 0;
            hits_seen   = 0;
            faults_seen = 0;
        end
        else begin
            if (req.valid && req.ready) begin
                awaited_outcomes.push_back(predict_access(op_t'(req.op), req.address,
                                                          req.write_value, req.mem_data,
                                                          req.mem_fault));
            end
            if (rsp.valid && rsp.ready) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("result beat arrived with no access outstanding");
                    fail_count++;
                end
                else begin
                    want = awaited_outcomes.pop_front();
                    compare_field("status", COUNT_BITS'(want.status),
                                  COUNT_BITS'(rsp.status));
                    compare_field("hit", COUNT_BITS'(want.hit), COUNT_BITS'(rsp.hit));
                    compare_field("read_data", COUNT_BITS'(want.read_data),
                                  COUNT_BITS'(rsp.read_data));
                    compare_field("access_total", want.access_total, rsp.access_total);
                    compare_field("hit_total", want.hit_total, rsp.hit_total);
                    compare_field("miss_total", want.miss_total, rsp.miss_total);
                    checked++;
                    if (want.hit) begin
                        hits_seen++;
                    end
                    if (want.status) begin
                        faults_seen++;
                    end
                end
            end
            pending = awaited_outcomes.size();
        end
    end

endmodule

// ----- verif/tb_direct_mapped_write_through_cache.sv -----
// ============================================================================
// tb_direct_mapped_write_through_cache
// Drives reads and writes into the cache and gives the verdict.
// ============================================================================
// A directed pass covers fills, hits, aliases within a line, allocation on
// write and faults of every kind. Random traffic follows, mostly drawn from a
// small working set of addresses so that lines are reused and evicted, with
// idle bursts on both channels except near the end of the run.

module tb_direct_mapped_write_through_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import dmwtc_pkg::*;

    localparam int HOT_COUNT = 12;

    logic clk = 1'b0;
    logic rst_n;

    dmwtc_req_if req_ch ();
    dmwtc_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int checked;
    int hits_seen;
    int faults_seen;

    int items_sent    = 0;
    bit sender_idle   = 1'b0;
    bit receiver_idle = 1'b0;

    logic [ADDRESS_BITS-1:0] hot_addr [HOT_COUNT];

    direct_mapped_write_through_cache u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dmwtc_access_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked),
        .hits_seen   (hits_seen),
        .faults_seen (faults_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one access beat and holds it until the cache takes it.
    task automatic drive_access(input op_t kind,
                                input logic [ADDRESS_BITS-1:0] addr,
                                input logic [WORD_BITS-1:0] wval,
                                input logic [WORD_BITS-1:0] mval,
                                input logic fault);
        req_ch.valid       <= 1'b1;
        req_ch.op          <= kind;
        req_ch.address     <= addr;
        req_ch.write_value <= wval;
        req_ch.mem_data    <= mval;
        req_ch.mem_fault   <= fault;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        items_sent++;
        if (sender_idle && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drive_random_access();
        logic [ADDRESS_BITS-1:0] addr;
        if ($urandom_range(0, 9) < 7) begin
            addr = hot_addr[$urandom_range(0, HOT_COUNT - 1)];
        end
        else begin
            addr = ADDRESS_BITS'($urandom_range(0, (1 << ADDRESS_BITS) - 1));
        end
        drive_access(op_t'($urandom_range(0, 1)), addr,
                     WORD_BITS'($urandom_range(0, (1 << WORD_BITS) - 1)),
                     WORD_BITS'($urandom_range(0, (1 << WORD_BITS) - 1)),
                     $urandom_range(0, 9) == 0);
    endtask

    // Holds the access channel quiet until every outstanding result is back.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (receiver_idle && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        int directed_count;
        req_ch.valid       <= 1'b0;
        req_ch.op          <= OP_READ;
        req_ch.address     <= '0;
        req_ch.write_value <= '0;
        req_ch.mem_data    <= '0;
        req_ch.mem_fault   <= 1'b0;
        rst_n              <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        // Fill, then a hit that ignores a fault, then an alias in the same line.
        drive_access(OP_READ,  7'h00, 16'h0000, 16'hFFFF, 1'b0);
        drive_access(OP_READ,  7'h00, 16'h1111, 16'h2222, 1'b1);
        drive_access(OP_READ,  7'h01, 16'h0000, 16'h1234, 1'b0);
        drive_access(OP_READ,  7'h00, 16'hFFFF, 16'h0000, 1'b0);
        drive_access(OP_WRITE, 7'h00, 16'hFFFF, 16'h0000, 1'b0);
        drive_access(OP_READ,  7'h00, 16'h0000, 16'h0000, 1'b0);
        // Allocation on write, then a faulting write that must change nothing.
        drive_access(OP_WRITE, 7'h7F, 16'h0000, 16'hFFFF, 1'b0);
        drive_access(OP_READ,  7'h7F, 16'hFFFF, 16'hAAAA, 1'b0);
        drive_access(OP_WRITE, 7'h7F, 16'h5555, 16'h0000, 1'b1);
        drive_access(OP_READ,  7'h7F, 16'h0000, 16'h5555, 1'b0);
        // A read miss that faults leaves the line empty.
        drive_access(OP_READ,  7'h40, 16'h0000, 16'hBEEF, 1'b1);
        drive_access(OP_READ,  7'h40, 16'h0000, 16'h8001, 1'b0);
        drive_access(OP_WRITE, 7'h4F, 16'h1234, 16'h0000, 1'b1);
        drive_access(OP_WRITE, 7'h4F, 16'h7FFE, 16'h0000, 1'b0);
        drive_access(OP_READ,  7'h40, 16'h0000, 16'h0F0F, 1'b0);
        drive_access(OP_READ,  7'h4F, 16'h0000, 16'h0000, 1'b0);
        drive_access(OP_WRITE, 7'h30, 16'hFFFF, 16'h0000, 1'b0);
        drive_access(OP_READ,  7'h30, 16'h0000, 16'h0000, 1'b0);
        drive_access(OP_WRITE, 7'h30, 16'h0001, 16'hFFFF, 1'b0);
        drive_access(OP_READ,  7'h3F, 16'hFFFF, 16'h8000, 1'b0);
        directed_count = items_sent;
        wait_for_drain();

        for (int chunk = 0; chunk < 17; chunk++) begin
            // The closing chunks run with both channels at full rate.
            sender_idle   = (chunk < 14) && ($urandom_range(0, 3) != 0);
            receiver_idle = (chunk < 14) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < HOT_COUNT; i++) begin
                hot_addr[i] = ADDRESS_BITS'($urandom_range(0, (1 << ADDRESS_BITS) - 1));
            end
            for (int n = 0; n < 100; n++) begin
                drive_random_access();
            end
            if (chunk == 5 || (chunk < 14 && $urandom_range(0, 5) == 0)) begin
                wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (8) @(posedge clk);

        $display("Covered %0d accesses (%0d directed), %0d results checked.",
                 items_sent, directed_count, checked);
        $display("Results included %0d hits and %0d accesses aborted by a memory fault.",
                 hits_seen, faults_seen);
        if (fail_count == 0) begin
            $display("direct_mapped_write_through_cache verification clean");
        end
        else begin
            $display("direct_mapped_write_through_cache verification failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("direct_mapped_write_through_cache verification failed");
        $finish;
    end

endmodule
